/* design/serial_frame_receiver_crc8_defines.svh */
// Assertion macros for the serial frame receiver checker.
// No dependencies; include by bare file name.
`ifndef SERIAL_FRAME_RECEIVER_CRC8_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CRC8_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sfr_crc8_pkg.sv */
// Types, constants and the CRC-8 byte step for the serial frame receiver.
// No dependencies.
package sfr_crc8_pkg;

    localparam int MAX_FRAME_BYTES   = 64;
    localparam int POS_W             = $clog2(MAX_FRAME_BYTES);
    localparam int FULL_W            = 9;
    localparam int PREHEADER_BYTES   = 5;
    localparam int OVERHEAD_BYTES    = 4;
    localparam int ADDR_INDEX        = 0;
    localparam int TYPE_INDEX        = 1;
    localparam int LENGTH_INDEX      = 2;
    localparam logic [7:0]  CRC_POLY = 8'hD5;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1500;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_GOOD = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] now_us;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [5:0]  byte_position;
        logic [7:0]  frame_address;
        logic [7:0]  frame_type;
        logic [7:0]  payload_length;
        logic [31:0] error_count;
    } t_out_item;

    // One byte through the MSB-first CRC-8, no reflection.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* design/serial_frame_receiver_crc8.sv */
// Serial frame receiver: takes one UART byte with its microsecond timestamp per
// transaction and returns one result per byte. Frames are address, type, length,
// payload, CRC-8 (poly 0xD5, init 0); a byte later than the timeout past the start
// time, which only a timeout resets, drops the partial frame. One item is accepted
// per cycle unless the output stalls; an input register and then a result register
// hold each byte, with the frame state updated in the single pass between them. A
// waiting result does not block the next input: the input register holds one more
// item while the output stalls. Depends on sfr_crc8_pkg.
module serial_frame_receiver_crc8 (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  sfr_crc8_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output sfr_crc8_pkg::t_out_item o_out,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [31:0]            i_cfg_data
);

    localparam int POS_W  = sfr_crc8_pkg::POS_W;
    localparam int FULL_W = sfr_crc8_pkg::FULL_W;

    logic                    r_in_valid;
    sfr_crc8_pkg::t_in_item  r_in;
    logic                    r_out_valid;
    sfr_crc8_pkg::t_out_item r_out;
    logic [31:0]             r_timeout;

    logic [POS_W-1:0] r_position, n_position;
    logic [7:0]       r_crc, n_crc;
    logic [31:0]      r_start_time, n_start_time;
    logic [7:0]       r_address, n_address;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_length, n_length;
    logic [31:0]      r_fail_count, n_fail_count;
    sfr_crc8_pkg::t_out_item n_out;

    logic              advance;
    logic [31:0]       elapsed;
    logic              timed_out;
    logic [POS_W-1:0]  pos_cur;
    logic [FULL_W-1:0] len_full;
    logic [FULL_W-1:0] full;
    logic [FULL_W-1:0] pos_next;
    logic [7:0]        crc_base;
    sfr_crc8_pkg::t_status status;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        elapsed      = r_in.now_us - r_start_time;
        timed_out    = elapsed > r_timeout;
        pos_cur      = timed_out ? '0 : r_position;
        n_start_time = timed_out ? r_in.now_us : r_start_time;

        len_full = FULL_W'(r_length) + FULL_W'(sfr_crc8_pkg::OVERHEAD_BYTES);
        if (pos_cur <= POS_W'(sfr_crc8_pkg::LENGTH_INDEX)) begin
            full = FULL_W'(sfr_crc8_pkg::PREHEADER_BYTES);
        end else if (len_full > FULL_W'(sfr_crc8_pkg::MAX_FRAME_BYTES)) begin
            full = FULL_W'(sfr_crc8_pkg::MAX_FRAME_BYTES);
        end else begin
            full = len_full;
        end

        pos_next     = FULL_W'(pos_cur) + FULL_W'(1);
        crc_base     = (pos_cur == POS_W'(sfr_crc8_pkg::ADDR_INDEX)) ? 8'd0 : r_crc;
        n_position   = pos_cur;
        n_crc        = r_crc;
        n_address    = r_address;
        n_type       = r_type;
        n_length     = r_length;
        n_fail_count = r_fail_count;
        status       = sfr_crc8_pkg::ST_BUSY;

        if (FULL_W'(pos_cur) < full) begin
            n_crc = crc_base;
            case (pos_cur)
                POS_W'(sfr_crc8_pkg::ADDR_INDEX):   n_address = r_in.rx_byte;
                POS_W'(sfr_crc8_pkg::TYPE_INDEX):   n_type    = r_in.rx_byte;
                POS_W'(sfr_crc8_pkg::LENGTH_INDEX): n_length  = r_in.rx_byte;
                default: ;
            endcase
            if (pos_next < full) begin
                n_crc      = sfr_crc8_pkg::crc8_step(crc_base, r_in.rx_byte);
                n_position = POS_W'(pos_next);
            end else begin
                // last byte of the frame carries the CRC
                n_position = '0;
                if (r_in.rx_byte == crc_base) begin
                    status = sfr_crc8_pkg::ST_GOOD;
                end else begin
                    status       = sfr_crc8_pkg::ST_BAD;
                    n_fail_count = r_fail_count + 32'd1;
                end
            end
        end

        n_out.status         = status;
        n_out.byte_position  = 6'(pos_cur);
        n_out.frame_address  = n_address;
        n_out.frame_type     = n_type;
        n_out.payload_length = n_length;
        n_out.error_count    = n_fail_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_timeout    <= sfr_crc8_pkg::TIMEOUT_RESET;
            r_position   <= '0;
            r_crc        <= '0;
            r_start_time <= '0;
            r_address    <= '0;
            r_type       <= '0;
            r_length     <= '0;
            r_fail_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_position   <= n_position;
                r_crc        <= n_crc;
                r_start_time <= n_start_time;
                r_address    <= n_address;
                r_type       <= n_type;
                r_length     <= n_length;
                r_fail_count <= n_fail_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

/* design/sfr_crc8_chk.sv */
// Port-level checker for serial_frame_receiver_crc8, bound to the top level.
// Depends on sfr_crc8_pkg and serial_frame_receiver_crc8_defines.svh.
`include "serial_frame_receiver_crc8_defines.svh"

module sfr_crc8_chk (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input sfr_crc8_pkg::t_out_item o_out
);

    // stalled result transaction holds
    `SFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid && $stable(o_out),
        "stalled result changed")

    // an empty output stage never stalls the input
    `SFR_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n,
        !o_out_valid, o_in_ready, "input stalled with empty output")

    // a frame ends no earlier than the byte after the length byte
    `SFR_ASSERT_NOW(a_end_position, i_clk, i_rst_n,
        o_out_valid && o_out.status != sfr_crc8_pkg::ST_BUSY,
        o_out.byte_position >= 6'd3, "frame ended too early")

    // the last slot of the largest frame always closes the frame
    `SFR_ASSERT_NOW(a_cap_closes, i_clk, i_rst_n,
        o_out_valid && o_out.status == sfr_crc8_pkg::ST_BUSY,
        o_out.byte_position != 6'(sfr_crc8_pkg::MAX_FRAME_BYTES - 1),
        "frame ran past maximum size")

endmodule

bind serial_frame_receiver_crc8 sfr_crc8_chk u_sfr_crc8_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

/* tb/tb.sv */
// Self-checking testbench for serial_frame_receiver_crc8: a queue-fed driver, a result
// monitor and an in-order frame predictor in one module.
// Depends on sfr_crc8_pkg and the serial_frame_receiver_crc8 RTL.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned PRINT_LIMIT = 100;
    localparam int unsigned PHASE_ITEMS = 200;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    sfr_crc8_pkg::t_in_item  in_item  = '0;
    logic                    out_ready = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [31:0]             cfg_data  = '0;
    logic                    in_ready;
    logic                    out_valid;
    logic                    cfg_ready;
    sfr_crc8_pkg::t_out_item out_item;

    // Stimulus and scoreboard storage
    sfr_crc8_pkg::t_in_item  rx_bytes_pending[$];
    sfr_crc8_pkg::t_out_item byte_reports_due[$];
    int unsigned queued_count   = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_gap       = 0;
    int unsigned ready_hold     = 0;
    bit          no_idle        = 1'b0;
    logic [31:0] stamp_us       = '0;

    // Predicted receiver state
    logic [6:0]  rcv_pos     = '0;
    logic [7:0]  rcv_crc     = '0;
    logic [31:0] rcv_start   = '0;
    logic [7:0]  rcv_addr    = '0;
    logic [7:0]  rcv_type    = '0;
    logic [7:0]  rcv_len     = '0;
    logic [31:0] rcv_errors  = '0;
    logic [31:0] rcv_timeout = sfr_crc8_pkg::TIMEOUT_RESET;

    serial_frame_receiver_crc8 u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8) r = r[7] ? ((r << 1) ^ sfr_crc8_pkg::CRC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch at result %0d: %s", results_seen, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    // Advance the predicted receiver by one byte and queue the report it produces.
    task automatic predict_frame_byte(input sfr_crc8_pkg::t_in_item item);
        logic [31:0]             elapsed;
        int unsigned             frame_len;
        sfr_crc8_pkg::t_out_item rpt;
        elapsed = item.now_us - rcv_start;
        if (elapsed > rcv_timeout) begin
            rcv_pos   = '0;
            rcv_start = item.now_us;
        end
        if (rcv_pos <= sfr_crc8_pkg::LENGTH_INDEX) begin
            frame_len = sfr_crc8_pkg::PREHEADER_BYTES;
        end else begin
            frame_len = rcv_len + sfr_crc8_pkg::OVERHEAD_BYTES;
            if (frame_len > sfr_crc8_pkg::MAX_FRAME_BYTES) begin
                frame_len = sfr_crc8_pkg::MAX_FRAME_BYTES;
            end
        end
        rpt.status        = sfr_crc8_pkg::ST_BUSY;
        rpt.byte_position = rcv_pos[5:0];
        if (rcv_pos < frame_len) begin
            if (rcv_pos == sfr_crc8_pkg::ADDR_INDEX) begin
                rcv_crc  = '0;
                rcv_addr = item.rx_byte;
            end else if (rcv_pos == sfr_crc8_pkg::TYPE_INDEX) begin
                rcv_type = item.rx_byte;
            end else if (rcv_pos == sfr_crc8_pkg::LENGTH_INDEX) begin
                rcv_len = item.rx_byte;
            end
            if (rcv_pos + 1 < frame_len) begin
                rcv_crc = crc8_fold(rcv_crc, item.rx_byte);
                rcv_pos = rcv_pos + 7'd1;
            end else begin
                rcv_pos = '0;
                if (item.rx_byte == rcv_crc) begin
                    rpt.status = sfr_crc8_pkg::ST_GOOD;
                end else begin
                    rpt.status = sfr_crc8_pkg::ST_BAD;
                    rcv_errors = rcv_errors + 32'd1;
                end
            end
        end
        rpt.frame_address  = rcv_addr;
        rpt.frame_type     = rcv_type;
        rpt.payload_length = rcv_len;
        rpt.error_count    = rcv_errors;
        byte_reports_due.push_back(rpt);
    endtask

    // Driver: present queued bytes, predict on each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready) predict_frame_byte(in_item);
            if (!in_valid || in_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (rx_bytes_pending.size() != 0) begin
                    in_item  <= rx_bytes_pending.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= draw_wait();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin : monitor
        int unsigned             hold;
        sfr_crc8_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            ready_hold <= 0;
        end else begin
            hold = ready_hold;
            if (out_valid && out_ready) begin
                if (byte_reports_due.size() == 0) begin
                    report_mismatch("result with no byte outstanding");
                end else begin
                    want = byte_reports_due.pop_front();
                    check_field("status", 32'(out_item.status), 32'(want.status));
                    check_field("byte_position", 32'(out_item.byte_position),
                                32'(want.byte_position));
                    check_field("frame_address", 32'(out_item.frame_address),
                                32'(want.frame_address));
                    check_field("frame_type", 32'(out_item.frame_type),
                                32'(want.frame_type));
                    check_field("payload_length", 32'(out_item.payload_length),
                                32'(want.payload_length));
                    check_field("error_count", out_item.error_count, want.error_count);
                end
                results_seen++;
                hold = draw_wait();
            end
            if (hold != 0) begin
                out_ready  <= 1'b0;
                ready_hold <= hold - 1;
            end else begin
                out_ready  <= 1'b1;
                ready_hold <= 0;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    task automatic write_timeout(input logic [31:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        rcv_timeout = value;
    endtask

    // Hold until every byte is accepted and every report is back, then let the pipe settle.
    task automatic wait_drained();
        while (rx_bytes_pending.size() != 0 || in_valid || byte_reports_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic [31:0] stamp);
        sfr_crc8_pkg::t_in_item item;
        item.rx_byte = data;
        item.now_us  = stamp;
        rx_bytes_pending.push_back(item);
        stamp_us = stamp;
        queued_count++;
    endtask

    // Build a frame of the given length (capped at the maximum size), optionally with a
    // bad check byte, cut short or with its last byte at the timeout. Unless the timeout
    // is maximal, a longer gap comes first so the receiver drops all and starts at index 0.
    task automatic queue_frame(input int unsigned len, input bit corrupt,
                               input int unsigned keep, input bit at_limit);
        logic [7:0]        fb[$];
        logic [7:0]        acc;
        logic [31:0]       t0;
        logic [31:0]       t;
        longint unsigned   jump;
        int unsigned       total;
        int unsigned       max_step;
        int unsigned       i;
        int unsigned       n;
        total = len + sfr_crc8_pkg::OVERHEAD_BYTES;
        if (total > sfr_crc8_pkg::MAX_FRAME_BYTES) total = sfr_crc8_pkg::MAX_FRAME_BYTES;
        fb.push_back(8'($urandom_range(0, 255)));
        fb.push_back(8'($urandom_range(0, 255)));
        fb.push_back(len[7:0]);
        while (fb.size() < total - 1) fb.push_back(8'($urandom_range(0, 255)));
        acc = '0;
        foreach (fb[k]) acc = crc8_fold(acc, fb[k]);
        fb.push_back(corrupt ? acc ^ (8'h01 << $urandom_range(0, 7)) : acc);
        n = (keep == 0 || keep > total) ? total : keep;
        if (rcv_timeout != 32'hFFFF_FFFF) begin
            jump = longint'(rcv_timeout) + 1 + $urandom_range(0, 3);
            if (jump > 64'hFFFF_FFFF) jump = 64'hFFFF_FFFF;
            stamp_us = stamp_us + jump[31:0];
        end
        t0 = stamp_us;
        max_step = rcv_timeout / 70;
        if (max_step > 20) max_step = 20;
        for (i = 0; i < n; i++) begin
            t = (i == 0) ? stamp_us : stamp_us + $urandom_range(0, max_step);
            // Land the last byte exactly on the timeout: it must still count.
            if (at_limit && i == n - 1) t = t0 + rcv_timeout;
            queue_byte(fb[i], t);
        end
    endtask

    task automatic queue_noise();
        int unsigned k;
        logic [31:0] t;
        k = $urandom_range(1, 6);
        repeat (k) begin
            if ($urandom_range(0, 3) == 0) t = $urandom;
            else t = stamp_us + $urandom_range(0, 20);
            queue_byte(8'($urandom_range(0, 255)), t);
        end
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned first;
        int unsigned sel;
        int unsigned len;
        first = queued_count;
        while (queued_count - first < count) begin
            sel = $urandom_range(0, 9);
            len = (sel < 7) ? $urandom_range(0, 12) :
                  (sel < 9) ? $urandom_range(13, 59) : $urandom_range(60, 255);
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                queue_noise();
            end else if (sel < 22) begin
                queue_frame(len, 1'b0, $urandom_range(1, 4), 1'b0);
            end else begin
                if ($urandom_range(0, 7) == 0) stamp_us = $urandom;
                queue_frame(len, $urandom_range(0, 4) == 0, 0, 1'b0);
            end
        end
    endtask

    task automatic queue_directed();
        queue_frame(0, 1'b0, 0, 1'b0);
        queue_frame(1, 1'b1, 0, 1'b0);
        // Partial frame, then dropped by the gap before the next one.
        queue_frame(5, 1'b0, 2, 1'b0);
        queue_frame(3, 1'b0, 0, 1'b1);
        // Frame that straddles the timestamp wrap.
        stamp_us = 32'hFFFF_FFF8 - 32'd1504;
        queue_frame(2, 1'b0, 0, 1'b0);
        queue_byte(8'hFF, 32'hFFFF_FFFF);
        queue_byte(8'h00, 32'h0000_0000);
    endtask

    initial begin : main
        int unsigned ph;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                1: write_timeout(32'd0);
                2: write_timeout(32'hFFFF_FFFF);
                3: write_timeout(32'd1);
                4: write_timeout($urandom_range(50, 100000));
                default: ;
            endcase
            @(negedge i_clk);
            no_idle = (ph == 2);
            if (ph == 0) begin
                queue_directed();
                wait_drained();
            end
            queue_random(PHASE_ITEMS);
            wait_drained();
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* serial_frame_receiver_crc8.f */
+incdir+design
design/sfr_crc8_pkg.sv
design/serial_frame_receiver_crc8.sv
design/sfr_crc8_chk.sv
tb/tb.sv
